/* rtl/core/jqwr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the job queue with removal.
// Depends on nothing; imported by job_queue_with_removal and its testbench.

package jqwr_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_HANDLE_BITS = 8;
   localparam int DEF_NUMBER_BITS = 16;

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_POP    = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_EMPTY     = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_DUPLICATE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_LOAD,
      ST_UNLINK,
      ST_FRONT,
      ST_LINK_PREV,
      ST_PUSH_LINK
   } state_type;

   // Field write enables of the entry memory.
   typedef struct packed {
      logic data;
      logic next_link;
      logic prev_link;
   } wr_mask_type;

endpackage

/* rtl/core/job_queue_with_removal.sv */
`timescale 1ns / 1ps
// Job queue with removal: a doubly linked list of job entries kept in one
// synchronous entry memory, driven by a sequencer. Depends on jqwr_pkg.
//
// A pop reads the front entry and unlinks it. A push scans every slot; with room on a
// non-empty queue it reads the back entry and writes and links the new one, and a
// duplicate ends the scan at its hit. A remove scans to the matching slot and unlinks
// it. The handle search reads one entry per cycle. One item at a time; a new item may
// start in the strobe cycle, and the receiver cannot stall the beat. Reset is
// synchronous and leaves the queue empty.

module job_queue_with_removal #(
   parameter int QUEUE_DEPTH = jqwr_pkg::DEF_QUEUE_DEPTH,
   parameter int HANDLE_BITS = jqwr_pkg::DEF_HANDLE_BITS,
   parameter int NUMBER_BITS = jqwr_pkg::DEF_NUMBER_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_action,
   input  logic [HANDLE_BITS-1:0]               req_job_handle,
   output logic                                 rsp_strobe,
   output logic [2:0]                           rsp_status,
   output logic [HANDLE_BITS-1:0]               rsp_result_handle,
   output logic [NUMBER_BITS-1:0]               rsp_result_job_number,
   output logic [HANDLE_BITS-1:0]               rsp_front_handle,
   output logic                                 rsp_front_valid,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]     rsp_entry_count
);
   import jqwr_pkg::*;

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(QUEUE_DEPTH);

   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [NUMBER_BITS-1:0] number;
      logic [IDX_W-1:0]       next_slot;
      logic [IDX_W-1:0]       prev_slot;
   } entry_type;

   entry_type entry_mem [QUEUE_DEPTH];

   state_type              state_ff, state_in;
   action_type             action_ff, action_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [IDX_W-1:0]       tail_ff, tail_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [QUEUE_DEPTH-1:0] used_ff, used_in;
   logic [HANDLE_BITS-1:0] front_ff, front_in;
   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                   scan_more_ff, scan_more_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_slot_ff, free_slot_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   entry_type              rec_ff, rec_in;
   entry_type              rd_data_ff;
   logic                   strobe_ff, strobe_in;
   status_type             status_ff, status_in;
   logic [HANDLE_BITS-1:0] res_handle_ff, res_handle_in;
   logic [NUMBER_BITS-1:0] res_number_ff, res_number_in;

   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;
   wr_mask_type            wr_mask;
   logic                   hit;
   logic                   miss_done;
   logic                   at_head;
   logic                   at_tail;
   logic [NUMBER_BITS-1:0] next_number;

   // Entry memory: one write address with field enables, one registered read.
   always_ff @(posedge clock) begin
      if (wr_mask.data) begin
         entry_mem[wr_addr].handle <= wr_data.handle;
         entry_mem[wr_addr].number <= wr_data.number;
      end
      if (wr_mask.next_link) begin
         entry_mem[wr_addr].next_slot <= wr_data.next_slot;
      end
      if (wr_mask.prev_link) begin
         entry_mem[wr_addr].prev_slot <= wr_data.prev_slot;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign hit       = cmp_valid_ff && used_ff[cmp_idx_ff] && (rd_data_ff.handle == handle_ff);
   assign miss_done = cmp_valid_ff && (cmp_idx_ff == LAST_IDX) && !hit;
   assign at_head   = (slot_ff == head_ff);
   assign at_tail   = (slot_ff == tail_ff);
   assign next_number = (rd_data_ff.number == '1) ? rd_data_ff.number
                                                  : rd_data_ff.number + NUMBER_BITS'(1);

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      handle_in     = handle_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      front_in      = front_ff;
      scan_idx_in   = scan_idx_ff;
      scan_more_in  = scan_more_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      slot_in       = slot_ff;
      rec_in        = rec_ff;
      strobe_in     = 1'b0;
      status_in     = status_ff;
      res_handle_in = res_handle_ff;
      res_number_in = res_number_ff;
      rd_addr       = scan_idx_ff;
      wr_addr       = slot_ff;
      wr_data       = rec_ff;
      wr_mask       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               action_in     = action_type'(req_action);
               handle_in     = req_job_handle;
               res_handle_in = '0;
               res_number_in = '0;
               scan_idx_in   = '0;
               scan_more_in  = 1'b1;
               free_found_in = 1'b0;
               unique case (req_action)
                  ACT_PUSH: begin
                     state_in = ST_SCAN;
                  end
                  ACT_POP: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = STAT_EMPTY;
                     end else begin
                        slot_in  = head_ff;
                        state_in = ST_FETCH;
                     end
                  end
                  ACT_REMOVE: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = STAT_EMPTY;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  ACT_CLEAR: begin
                     used_in   = '0;
                     head_in   = '0;
                     tail_in   = '0;
                     count_in  = '0;
                     strobe_in = 1'b1;
                     status_in = STAT_OK;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Reads are issued one slot per cycle; each compare sees the
            // registered read of the slot issued in the cycle before.
            rd_addr      = scan_idx_ff;
            cmp_valid_in = scan_more_ff;
            cmp_idx_in   = scan_idx_ff;
            if (scan_more_ff) begin
               if (!used_ff[scan_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = scan_idx_ff;
               end
               if (scan_idx_ff == LAST_IDX) begin
                  scan_more_in = 1'b0;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end
            if (hit) begin
               if (action_ff == ACT_PUSH) begin
                  strobe_in = 1'b1;
                  status_in = STAT_DUPLICATE;
                  state_in  = ST_IDLE;
               end else begin
                  rec_in   = rd_data_ff;
                  slot_in  = cmp_idx_ff;
                  state_in = ST_UNLINK;
               end
            end else if (miss_done) begin
               if (action_ff != ACT_PUSH) begin
                  strobe_in = 1'b1;
                  status_in = STAT_NOT_FOUND;
                  state_in  = ST_IDLE;
               end else if (count_ff >= FULL_CNT || !free_found_ff) begin
                  strobe_in = 1'b1;
                  status_in = STAT_FULL;
                  state_in  = ST_IDLE;
               end else if (count_ff == '0) begin
                  wr_addr           = free_slot_ff;
                  wr_data.handle    = handle_ff;
                  wr_data.number    = NUMBER_BITS'(1);
                  wr_data.next_slot = free_slot_ff;
                  wr_data.prev_slot = free_slot_ff;
                  wr_mask           = '1;
                  used_in[free_slot_ff] = 1'b1;
                  head_in       = free_slot_ff;
                  tail_in       = free_slot_ff;
                  count_in      = COUNT_W'(1);
                  front_in      = handle_ff;
                  strobe_in     = 1'b1;
                  status_in     = STAT_OK;
                  res_handle_in = handle_ff;
                  res_number_in = NUMBER_BITS'(1);
                  state_in      = ST_IDLE;
               end else begin
                  slot_in  = free_slot_ff;
                  state_in = ST_FETCH;
               end
            end
         end

         ST_FETCH: begin
            // A push reads the back entry for its number; a pop reads the front.
            rd_addr  = (action_ff == ACT_PUSH) ? tail_ff : slot_ff;
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            if (action_ff == ACT_PUSH) begin
               wr_addr           = slot_ff;
               wr_data.handle    = handle_ff;
               wr_data.number    = next_number;
               wr_data.next_slot = slot_ff;
               wr_data.prev_slot = tail_ff;
               wr_mask           = '1;
               rec_in.number     = next_number;
               state_in          = ST_PUSH_LINK;
            end else begin
               rec_in   = rd_data_ff;
               state_in = ST_UNLINK;
            end
         end

         ST_PUSH_LINK: begin
            wr_addr           = tail_ff;
            wr_data.next_slot = slot_ff;
            wr_mask.next_link = 1'b1;
            used_in[slot_ff]  = 1'b1;
            tail_in       = slot_ff;
            count_in      = count_ff + COUNT_W'(1);
            strobe_in     = 1'b1;
            status_in     = STAT_OK;
            res_handle_in = handle_ff;
            res_number_in = rec_ff.number;
            state_in      = ST_IDLE;
         end

         ST_UNLINK: begin
            used_in[slot_ff] = 1'b0;
            res_handle_in    = rec_ff.handle;
            res_number_in    = rec_ff.number;
            status_in        = STAT_OK;
            priority if (at_head && at_tail) begin
               head_in   = '0;
               tail_in   = '0;
               count_in  = count_ff - COUNT_W'(1);
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else if (at_head) begin
               // The new front's handle comes from a read of the next entry.
               head_in  = rec_ff.next_slot;
               count_in = count_ff - COUNT_W'(1);
               rd_addr  = rec_ff.next_slot;
               state_in = ST_FRONT;
            end else if (at_tail) begin
               tail_in   = rec_ff.prev_slot;
               count_in  = count_ff - COUNT_W'(1);
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               wr_addr           = rec_ff.prev_slot;
               wr_data.next_slot = rec_ff.next_slot;
               wr_mask.next_link = 1'b1;
               count_in          = count_ff - COUNT_W'(1);
               state_in          = ST_LINK_PREV;
            end
         end

         ST_FRONT: begin
            front_in  = rd_data_ff.handle;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end

         ST_LINK_PREV: begin
            wr_addr           = rec_ff.next_slot;
            wr_data.prev_slot = rec_ff.prev_slot;
            wr_mask.prev_link = 1'b1;
            strobe_in         = 1'b1;
            state_in          = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         action_ff     <= ACT_PUSH;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         used_ff       <= '0;
         scan_idx_ff   <= '0;
         scan_more_ff  <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         strobe_ff     <= 1'b0;
         status_ff     <= STAT_OK;
      end else begin
         state_ff      <= state_in;
         action_ff     <= action_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         used_ff       <= used_in;
         scan_idx_ff   <= scan_idx_in;
         scan_more_ff  <= scan_more_in;
         cmp_valid_ff  <= cmp_valid_in;
         free_found_ff <= free_found_in;
         strobe_ff     <= strobe_in;
         status_ff     <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff     <= handle_in;
      front_ff      <= front_in;
      cmp_idx_ff    <= cmp_idx_in;
      free_slot_ff  <= free_slot_in;
      slot_ff       <= slot_in;
      rec_ff        <= rec_in;
      res_handle_ff <= res_handle_in;
      res_number_ff <= res_number_in;
   end

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_strobe            = strobe_ff;
   assign rsp_status            = status_ff;
   assign rsp_result_handle     = res_handle_ff;
   assign rsp_result_job_number = res_number_ff;
   assign rsp_front_valid       = (count_ff != '0);
   assign rsp_front_handle      = (count_ff != '0) ? front_ff : '0;
   assign rsp_entry_count       = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above queue depth");

   a_used_matches_count: assert property (@(posedge clock) disable iff (reset)
      COUNT_W'($countones(used_ff)) == count_ff)
      else $error("in-use bits disagree with entry count");

   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (state_ff == ST_IDLE))
      else $error("result beat while the sequencer is busy");

   a_ends_in_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && count_ff != '0) |-> (used_ff[head_ff] && used_ff[tail_ff]))
      else $error("front or back slot not in use");

   a_one_beat_per_item: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff || $past(start && !busy))
      else $error("result beat without an accepted item");

endmodule

/* tb/sv/job_queue_with_removal_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for job_queue_with_removal: directed table and random phases,
// checked against an ordered-list model of the queue or against pinned directed outcomes.
// Depends on jqwr_pkg and the job_queue_with_removal RTL.

module job_queue_with_removal_tb;
   import jqwr_pkg::*;

   localparam int DEPTH       = DEF_QUEUE_DEPTH;
   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int DRAIN_WAIT  = DEPTH + 14;

   typedef struct packed {
      status_type  status;
      logic [7:0]  handle;
      logic [15:0] number;
      logic [7:0]  front;
      logic        valid;
      logic [4:0]  count;
   } job_outcome_t;

   typedef struct packed {
      logic [7:0]  handle;
      logic [15:0] number;
   } queued_job_t;

   typedef struct packed {
      action_type   act;
      logic [7:0]   handle;
      logic         pinned;
      job_outcome_t outcome;
   } directed_row_t;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   localparam job_outcome_t NO_PIN = '0;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = ACT_CLEAR;
   logic [7:0]  req_job_handle = 8'h00;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_result_handle;
   logic [15:0] rsp_result_job_number;
   logic [7:0]  rsp_front_handle;
   logic        rsp_front_valid;
   logic [4:0]  rsp_entry_count;

   // A pinned expectation travels with its beat and replaces the model's answer.
   logic         pin_valid = 1'b0;
   job_outcome_t pin_outcome = '0;

   queued_job_t   job_line[$];
   job_outcome_t  pending_outcomes[$];
   directed_row_t directed_rows[30];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            rsp_beats = 0;

   job_queue_with_removal DUT (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_action            (req_action),
      .req_job_handle        (req_job_handle),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_result_handle     (rsp_result_handle),
      .rsp_result_job_number (rsp_result_job_number),
      .rsp_front_handle      (rsp_front_handle),
      .rsp_front_valid       (rsp_front_valid),
      .rsp_entry_count       (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic job_outcome_t known(status_type st, logic [7:0] rh, logic [15:0] rn,
                                          logic [7:0] fh, logic fv, logic [4:0] cnt);
      job_outcome_t outcome;
      outcome.status = st;
      outcome.handle = rh;
      outcome.number = rn;
      outcome.front  = fh;
      outcome.valid  = fv;
      outcome.count  = cnt;
      return outcome;
   endfunction

   // Applies one action to the ordered job list and returns what the block should report.
   function automatic job_outcome_t apply_job_action(action_type act, logic [7:0] handle);
      job_outcome_t outcome;
      queued_job_t  job;
      int           idx;
      outcome = '0;
      outcome.status = STAT_OK;
      idx = -1;
      foreach (job_line[i])
         if (job_line[i].handle == handle) idx = i;
      case (act)
         ACT_PUSH: begin
            if (idx >= 0) begin
               outcome.status = STAT_DUPLICATE;
            end else if (job_line.size() >= DEPTH) begin
               outcome.status = STAT_FULL;
            end else begin
               job.handle = handle;
               if (job_line.size() == 0) job.number = 16'd1;
               else if (job_line[$].number == 16'hFFFF) job.number = 16'hFFFF;
               else job.number = job_line[$].number + 16'd1;
               job_line.push_back(job);
               outcome.handle = job.handle;
               outcome.number = job.number;
            end
         end
         ACT_POP, ACT_REMOVE: begin
            if (job_line.size() == 0) begin
               outcome.status = STAT_EMPTY;
            end else begin
               if (act == ACT_POP) idx = 0;
               if (idx < 0) begin
                  outcome.status = STAT_NOT_FOUND;
               end else begin
                  outcome.handle = job_line[idx].handle;
                  outcome.number = job_line[idx].number;
                  job_line.delete(idx);
               end
            end
         end
         default: job_line.delete();
      endcase
      outcome.count = 5'(job_line.size());
      if (job_line.size() != 0) begin
         outcome.valid = 1'b1;
         outcome.front = job_line[0].handle;
      end
      return outcome;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t beat %0d: %s", $time, rsp_beats, msg);
      mismatch_count++;
   endtask

   task automatic check_outcome(input job_outcome_t want);
      if (rsp_status !== want.status)
         report_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
      if (rsp_result_handle !== want.handle)
         report_mismatch($sformatf("result_handle got %0h want %0h",
                                   rsp_result_handle, want.handle));
      if (rsp_result_job_number !== want.number)
         report_mismatch($sformatf("result_job_number got %0d want %0d",
                                   rsp_result_job_number, want.number));
      if (rsp_front_handle !== want.front)
         report_mismatch($sformatf("front_handle got %0h want %0h",
                                   rsp_front_handle, want.front));
      if (rsp_front_valid !== want.valid)
         report_mismatch($sformatf("front_valid got %0b want %0b",
                                   rsp_front_valid, want.valid));
      if (rsp_entry_count !== want.count)
         report_mismatch($sformatf("entry_count got %0d want %0d",
                                   rsp_entry_count, want.count));
   endtask

   // Results are checked before the beat accepted at the same edge is predicted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("result with no expectation waiting");
            end else begin
               check_outcome(pending_outcomes.pop_front());
            end
            rsp_beats++;
         end
         if (start && !busy) begin
            job_outcome_t predicted;
            predicted = apply_job_action(action_type'(req_action), req_job_handle);
            pending_outcomes.push_back(pin_valid ? pin_outcome : predicted);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Holds the beat on the request ports until the block takes it.
   task automatic send_job(input action_type act, input logic [7:0] handle, input logic pinned,
                           input job_outcome_t outcome, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_action     <= act;
      req_job_handle <= handle;
      pin_valid      <= pinned;
      pin_outcome    <= outcome;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      mix_type    mix;
      action_type act;
      logic [7:0] pool[20];
      logic [7:0] handle;
      int         push_cut;
      int         pop_cut;
      int         remove_cut;
      int         roll;
      bit         quiet;

      directed_rows = '{
         '{ACT_POP,    8'h00, 1'b1, known(STAT_EMPTY,     8'h00, 16'd0, 8'h00, 1'b0, 5'd0)},
         '{ACT_REMOVE, 8'hFF, 1'b1, known(STAT_EMPTY,     8'h00, 16'd0, 8'h00, 1'b0, 5'd0)},
         '{ACT_PUSH,   8'h00, 1'b1, known(STAT_OK,        8'h00, 16'd1, 8'h00, 1'b1, 5'd1)},
         '{ACT_PUSH,   8'h00, 1'b1, known(STAT_DUPLICATE, 8'h00, 16'd0, 8'h00, 1'b1, 5'd1)},
         '{ACT_REMOVE, 8'h00, 1'b1, known(STAT_OK,        8'h00, 16'd1, 8'h00, 1'b0, 5'd0)},
         '{ACT_PUSH, 8'h01, 1'b0, NO_PIN}, '{ACT_PUSH, 8'h02, 1'b0, NO_PIN},
         '{ACT_PUSH, 8'h04, 1'b0, NO_PIN}, '{ACT_PUSH, 8'h08, 1'b0, NO_PIN},
         '{ACT_PUSH, 8'h10, 1'b0, NO_PIN}, '{ACT_PUSH, 8'h20, 1'b0, NO_PIN},
         '{ACT_PUSH, 8'h40, 1'b0, NO_PIN}, '{ACT_PUSH, 8'h80, 1'b0, NO_PIN},
         '{ACT_PUSH, 8'hFE, 1'b0, NO_PIN}, '{ACT_PUSH, 8'hFD, 1'b0, NO_PIN},
         '{ACT_PUSH, 8'hFB, 1'b0, NO_PIN}, '{ACT_PUSH, 8'hF7, 1'b0, NO_PIN},
         '{ACT_PUSH, 8'hEF, 1'b0, NO_PIN}, '{ACT_PUSH, 8'hDF, 1'b0, NO_PIN},
         '{ACT_PUSH, 8'hBF, 1'b0, NO_PIN}, '{ACT_PUSH, 8'hFF, 1'b0, NO_PIN},
         '{ACT_PUSH,   8'h55, 1'b1, known(STAT_FULL,      8'h00, 16'd0, 8'h01, 1'b1, 5'd16)},
         '{ACT_PUSH,   8'h10, 1'b1, known(STAT_DUPLICATE, 8'h00, 16'd0, 8'h01, 1'b1, 5'd16)},
         '{ACT_REMOVE, 8'h55, 1'b1, known(STAT_NOT_FOUND, 8'h00, 16'd0, 8'h01, 1'b1, 5'd16)},
         '{ACT_REMOVE, 8'h80, 1'b0, NO_PIN},
         '{ACT_REMOVE, 8'hFF, 1'b0, NO_PIN},
         '{ACT_PUSH,   8'h55, 1'b0, NO_PIN},
         '{ACT_POP,    8'h00, 1'b0, NO_PIN},
         '{ACT_CLEAR,  8'hFF, 1'b1, known(STAT_OK,        8'h00, 16'd0, 8'h00, 1'b0, 5'd0)},
         '{ACT_POP,    8'h00, 1'b1, known(STAT_EMPTY,     8'h00, 16'd0, 8'h00, 1'b0, 5'd0)}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_job(directed_rows[i].act, directed_rows[i].handle, directed_rows[i].pinned,
                  directed_rows[i].outcome, $urandom_range(0, 19));

      // Each phase leans toward filling, draining or neither, and draws most handles from a
      // small pool so that duplicates, hits and misses on remove all come up often.
      for (int phase = 0; phase < 31; phase++) begin
         mix   = mix_type'($urandom_range(0, 2));
         quiet = ($urandom_range(0, 3) == 0);
         foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
         case (mix)
            MIX_FILL: begin
               push_cut = 65; pop_cut = 75; remove_cut = 97;
            end
            MIX_DRAIN: begin
               push_cut = 20; pop_cut = 55; remove_cut = 98;
            end
            default: begin
               push_cut = 40; pop_cut = 62; remove_cut = 97;
            end
         endcase
         for (int n = 0; n < 50; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < push_cut) act = ACT_PUSH;
            else if (roll < pop_cut) act = ACT_POP;
            else if (roll < remove_cut) act = ACT_REMOVE;
            else act = ACT_CLEAR;
            if ($urandom_range(0, 9) == 0) handle = 8'($urandom_range(0, 255));
            else handle = pool[$urandom_range(0, 19)];
            send_job(act, handle, 1'b0, NO_PIN, quiet ? 0 : $urandom_range(0, 19));
         end
      end
      start <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/jqwr_pkg.sv
rtl/core/job_queue_with_removal.sv
tb/sv/job_queue_with_removal_tb.sv
